/* design/dcc_pkg.sv */
package dcc_pkg;

  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned PreambleReset = 14;
  localparam int unsigned MaxPreamble   = 27;
  localparam int unsigned BodyBits      = 4 * 9 + 1;

  localparam logic [7:0]  InstrByte    = 8'h3F;
  localparam logic [6:0]  CodeMask     = 7'h7F;
  localparam logic [10:0] FullFraction = 11'd1024;
  localparam logic [6:0]  SpeedSteps   = 7'd125;

  typedef enum logic [1:0] {
    CMD_SPEED = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_ESTOP = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // One formed packet, ready for the serializer.
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] check;
    logic [4:0] pre;
  } pkt_t;

endpackage

/* design/dcc_front.sv */
module dcc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    command,
  input  logic [7:0]    address,
  input  logic [10:0]   speed_fraction,
  input  logic          forward,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [4:0]    cfg_data,
  output logic          pkt_valid,
  input  logic          pkt_ready,
  output dcc_pkg::pkt_t pkt
);

  logic [4:0]    preamble_length;
  logic [4:0]    pre_clamped;
  logic [10:0]   frac_clamped;
  logic [17:0]   product;
  logic [6:0]    code;
  logic          fwd;
  logic [7:0]    data;
  dcc_pkg::pkt_t pkt_next;
  dcc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !pkt_valid || pkt_ready;
  assign cmd       = dcc_pkg::cmd_t'(command);

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= 5'(dcc_pkg::PreambleReset);
    end else if (cfg_valid && cfg_ready) begin
      preamble_length <= cfg_data;
    end
  end

  always_comb begin
    frac_clamped = (speed_fraction > dcc_pkg::FullFraction) ? dcc_pkg::FullFraction
                                                            : speed_fraction;
    product = 18'(frac_clamped) * 18'(dcc_pkg::SpeedSteps);
    code    = 7'd0;
    fwd     = 1'b1;
    unique case (cmd)
      dcc_pkg::CMD_SPEED: begin
        // zero speed goes out as a plain stop
        if (speed_fraction != 11'd0) begin
          code = 7'(product[17:10] + 8'd2);
          fwd  = forward;
        end
      end
      dcc_pkg::CMD_ESTOP: code = 7'd1;
      default:            code = 7'd0;
    endcase
    data = {fwd, code & dcc_pkg::CodeMask};
    pre_clamped = (preamble_length > 5'(dcc_pkg::MaxPreamble)) ?
                  5'(dcc_pkg::MaxPreamble) : preamble_length;
    pkt_next.addr  = address;
    pkt_next.data  = data;
    pkt_next.check = address ^ dcc_pkg::InstrByte ^ data;
    pkt_next.pre   = pre_clamped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (s_tready) begin
      // drop the unused command code
      pkt_valid <= s_tvalid && (cmd != dcc_pkg::CMD_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      pkt <= pkt_next;
    end
  end

endmodule

/* design/dcc_queue.sv */
module dcc_queue #(
  parameter int unsigned DEPTH = dcc_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  dcc_pkg::pkt_t wr_pkt,
  output logic          rd_valid,
  input  logic          rd_ready,
  output dcc_pkg::pkt_t rd_pkt
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  dcc_pkg::pkt_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != CntW'(DEPTH));
  assign rd_valid = (count != CntW'(0));
  assign rd_pkt   = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(DEPTH - 1)) ? PtrW'(0) : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wrap_inc(wr_ptr);
      if (do_rd) rd_ptr <= wrap_inc(rd_ptr);
      if (do_wr && !do_rd)      count <= CntW'(count + 1'b1);
      else if (do_rd && !do_wr) count <= CntW'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_pkt;
    end
  end

endmodule

/* design/dcc_back.sv */
module dcc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pkt_valid,
  output logic          pkt_ready,
  input  dcc_pkg::pkt_t pkt,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic          line_bit,
  output logic          last
);

  localparam int unsigned BodyW = $clog2(dcc_pkg::BodyBits + 1);

  logic                            busy;
  logic [4:0]                      pre_cnt;
  logic [BodyW-1:0]                body_cnt;
  logic [dcc_pkg::BodyBits-1:0]    shreg;
  logic [dcc_pkg::BodyBits-1:0]    load_bits;
  logic                            advance;
  logic                            finishing;

  assign advance   = !m_tvalid || m_tready;
  assign finishing = busy && advance && (pre_cnt == 5'd0) && (body_cnt == BodyW'(1));
  assign pkt_ready = !busy || finishing;
  assign load_bits = {1'b0, pkt.addr, 1'b0, dcc_pkg::InstrByte,
                      1'b0, pkt.data, 1'b0, pkt.check, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      pre_cnt  <= '0;
      body_cnt <= '0;
    end else begin
      if (advance) m_tvalid <= busy;
      if (!busy) begin
        if (pkt_valid) begin
          busy     <= 1'b1;
          pre_cnt  <= pkt.pre;
          body_cnt <= BodyW'(dcc_pkg::BodyBits);
          shreg    <= load_bits;
        end
      end else if (advance) begin
        if (pre_cnt != 5'd0) begin
          line_bit <= 1'b1;
          last     <= 1'b0;
          pre_cnt  <= pre_cnt - 5'd1;
        end else begin
          // shift the body out MSB first, closing one last
          line_bit <= shreg[dcc_pkg::BodyBits-1];
          last     <= (body_cnt == BodyW'(1));
          if (finishing) begin
            // take the next packet behind the closing beat
            busy <= pkt_valid;
            if (pkt_valid) begin
              pre_cnt  <= pkt.pre;
              body_cnt <= BodyW'(dcc_pkg::BodyBits);
              shreg    <= load_bits;
            end
          end else begin
            shreg    <= {shreg[dcc_pkg::BodyBits-2:0], 1'b0};
            body_cnt <= BodyW'(body_cnt - 1'b1);
          end
        end
      end
    end
  end

endmodule

/* design/dcc_speed_packet_serializer.sv */
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    tuser: command; tdata: address, speed_fraction, forward
// m_*      out  m_tvalid / m_tready    tdata: line_bit; tlast: last
// cfg_*    in   cfg_valid / cfg_ready  cfg_data: preamble_length
//
// One packet takes preamble_length (capped at 27) + 37 beats on m_*, one bit a cycle
// unless m_tready stalls it. The next packet loads on the closing beat, so packets
// follow with no gap when one is queued. The bit serializer sets the rate; the front
// forms the next packet while one is sent.
// rst is synchronous; it restores preamble_length to 14 and empties the queue.
// Either side may stall; a stalled output beat holds, and the queue absorbs the front.
module dcc_speed_packet_serializer #(
  parameter int unsigned QUEUE_DEPTH = dcc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // address[7:0], speed_fraction[18:8], forward[19], zero
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // line_bit[0], zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  logic          f_valid;
  logic          f_ready;
  dcc_pkg::pkt_t f_pkt;
  logic          q_valid;
  logic          q_ready;
  dcc_pkg::pkt_t q_pkt;
  logic          line_bit;

  dcc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .command        (s_tuser),
    .address        (s_tdata[7:0]),
    .speed_fraction (s_tdata[18:8]),
    .forward        (s_tdata[19]),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .pkt_valid      (f_valid),
    .pkt_ready      (f_ready),
    .pkt            (f_pkt)
  );

  dcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_pkt   (f_pkt),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_pkt   (q_pkt)
  );

  dcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (q_valid),
    .pkt_ready (q_ready),
    .pkt       (q_pkt),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .line_bit  (line_bit),
    .last      (m_tlast)
  );

  assign m_tdata = {7'd0, line_bit};

endmodule

/* sim/dcc_speed_packet_serializer_tb.sv */
`timescale 1ns / 1ps

module dcc_speed_packet_serializer_tb;

  localparam int unsigned StopCode     = 0;
  localparam int unsigned EstopCode    = 1;
  localparam int unsigned SpeedBase    = 2;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned MaxPrinted   = 30;

  typedef struct packed {
    logic line_bit;
    logic last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = dcc_pkg::CMD_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  // Preamble length the block should be using now.
  logic [4:0]  preamble_len = 5'(dcc_pkg::PreambleReset);
  beat_t       packet_bits_due[$];
  int          mismatch_count = 0;
  int          beats_seen = 0;

  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_count = 0;
  int          rx_stall_left = 0;

  dcc_speed_packet_serializer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted)
      $display("mismatch at %0t, beat %0d: %s", $time, beats_seen, msg);
  endtask

  function automatic void expect_beat(input logic line_bit, input logic last);
    beat_t b;
    b.line_bit = line_bit;
    b.last     = last;
    packet_bits_due.push_back(b);
  endfunction

  // Build the bit train of one command: preamble ones, four framed bytes, end bit.
  function automatic void predict_packet_bits(input dcc_pkg::cmd_t cmd,
                                              input logic [7:0] addr,
                                              input logic [10:0] frac, input logic fwd);
    logic [6:0]  code;
    logic [7:0]  data_byte;
    logic [7:0]  bytes [4];
    int unsigned pre;
    if (cmd == dcc_pkg::CMD_NONE) return;
    if (cmd == dcc_pkg::CMD_SPEED && frac == '0) cmd = dcc_pkg::CMD_STOP;
    case (cmd)
      dcc_pkg::CMD_STOP: begin
        code = 7'(StopCode);
        fwd  = 1'b1;
      end
      dcc_pkg::CMD_ESTOP: begin
        code = 7'(EstopCode);
        fwd  = 1'b1;
      end
      default: begin
        if (frac > dcc_pkg::FullFraction) frac = dcc_pkg::FullFraction;
        code = 7'(SpeedBase + (int'(frac) * int'(dcc_pkg::SpeedSteps))
                              / int'(dcc_pkg::FullFraction));
      end
    endcase
    data_byte = {fwd, code & dcc_pkg::CodeMask};
    bytes[0] = addr;
    bytes[1] = dcc_pkg::InstrByte;
    bytes[2] = data_byte;
    bytes[3] = addr ^ dcc_pkg::InstrByte ^ data_byte;
    pre = (preamble_len > dcc_pkg::MaxPreamble) ? dcc_pkg::MaxPreamble : preamble_len;
    repeat (pre) expect_beat(1'b1, 1'b0);
    foreach (bytes[n]) begin
      expect_beat(1'b0, 1'b0);
      for (int i = 7; i >= 0; i--) expect_beat(bytes[n][i], 1'b0);
    end
    expect_beat(1'b1, 1'b1);
  endfunction

  // Check every accepted output beat against the oldest expected bit.
  always @(posedge clk) begin
    beat_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (packet_bits_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat line_bit=%0b last=%0b", m_tdata[0], m_tlast));
      end else begin
        due = packet_bits_due.pop_front();
        if (m_tdata[0] !== due.line_bit)
          report_mismatch($sformatf("line_bit got %0b want %0b", m_tdata[0], due.line_bit));
        if (m_tlast !== due.last)
          report_mismatch($sformatf("last got %0b want %0b", m_tlast, due.last));
      end
      beats_seen++;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps pushing.
  always @(posedge clk) begin
    if (!hold_go) begin
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_count == RxHoldCycles) begin
      hold_done <= 1'b1;
    end else begin
      hold_count <= hold_count + 1;
    end
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      m_tready <= 1'b0;
    end else if (calm || rx_stall_left == 0) begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) rx_stall_left <= $urandom_range(1, 7);
    end else begin
      m_tready      <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end
  end

  task automatic send_command(input dcc_pkg::cmd_t cmd, input logic [7:0] addr,
                              input logic [10:0] frac, input logic fwd);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, fwd, frac, addr};
    do @(posedge clk); while (!s_tready);
    predict_packet_bits(cmd, addr, frac, fwd);
  endtask

  task automatic send_random_command();
    dcc_pkg::cmd_t cmd;
    logic [10:0]   frac;
    int            pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)       cmd = dcc_pkg::CMD_SPEED;
    else if (pick == 7) cmd = dcc_pkg::CMD_STOP;
    else if (pick == 8) cmd = dcc_pkg::CMD_ESTOP;
    else                cmd = dcc_pkg::CMD_NONE;
    pick = $urandom_range(0, 7);
    case (pick)
      0:       frac = '0;
      1:       frac = dcc_pkg::FullFraction;
      2:       frac = 11'($urandom_range(1025, 2047));
      default: frac = 11'($urandom_range(1, 1023));
    endcase
    send_command(cmd, 8'($urandom), frac, 1'($urandom));
  endtask

  // Drop valid, wait for every expected bit, then let the block settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (packet_bits_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_preamble(input logic [4:0] len);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    preamble_len = len;
  endtask

  task automatic test_directed_packets();
    send_command(dcc_pkg::CMD_SPEED, 8'h00, 11'd1024, 1'b1);
    send_command(dcc_pkg::CMD_SPEED, 8'hFF, 11'd0,    1'b0);  // zero speed goes out as stop
    send_command(dcc_pkg::CMD_SPEED, 8'h01, 11'd1,    1'b0);
    send_command(dcc_pkg::CMD_SPEED, 8'h80, 11'd8,    1'b1);
    send_command(dcc_pkg::CMD_SPEED, 8'h7F, 11'd9,    1'b0);
    send_command(dcc_pkg::CMD_SPEED, 8'h3C, 11'd512,  1'b0);
    send_command(dcc_pkg::CMD_SPEED, 8'hA5, 11'd1023, 1'b1);
    send_command(dcc_pkg::CMD_SPEED, 8'h5A, 11'd1025, 1'b0);  // above full speed clamps
    send_command(dcc_pkg::CMD_SPEED, 8'hC3, 11'd2047, 1'b1);
    send_command(dcc_pkg::CMD_STOP,  8'h5A, 11'd777,  1'b0);  // stop forces forward
    send_command(dcc_pkg::CMD_ESTOP, 8'hFF, 11'd2047, 1'b0);
    send_command(dcc_pkg::CMD_ESTOP, 8'h00, 11'd0,    1'b1);
    send_command(dcc_pkg::CMD_NONE,  8'hFF, 11'd2047, 1'b1);  // unused command, no bits
    send_command(dcc_pkg::CMD_SPEED, 8'h3F, 11'd100,  1'b1);
    wait_drained();
  endtask

  task automatic test_preamble_extremes();
    logic [4:0] lens [5];
    lens = '{5'd10, 5'd27, 5'd31, 5'd0, 5'd5};
    foreach (lens[n]) begin
      write_preamble(lens[n]);
      send_command(dcc_pkg::CMD_SPEED, 8'($urandom), 11'($urandom_range(1, 1024)),
                   1'($urandom));
      send_command(dcc_pkg::CMD_ESTOP, 8'($urandom), 11'($urandom), 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_input_backpressure();
    write_preamble(5'($urandom_range(10, 27)));
    fork
      begin
        hold_go <= 1'b1;
        do @(posedge clk); while (!hold_done);
        hold_go <= 1'b0;
      end
      begin
        repeat (10) send_random_command();
        s_tvalid <= 1'b0;
      end
    join
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    write_preamble(5'($urandom_range(0, 31)));
    repeat (count) send_random_command();
    wait_drained();
  endtask

  task automatic test_steady_stream(input int count);
    write_preamble(5'd14);
    calm = 1'b1;
    repeat (count) send_random_command();
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_packets();
    test_preamble_extremes();
    test_input_backpressure();
    repeat (4) test_random_traffic(37);
    test_steady_stream(40);
    if (mismatch_count == 0 && packet_bits_due.size() == 0)
      $display("[dcc_speed_packet_serializer] OK");
    else
      $display("[dcc_speed_packet_serializer] ERROR");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[dcc_speed_packet_serializer] ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/dcc_pkg.sv
design/dcc_front.sv
design/dcc_queue.sv
design/dcc_back.sv
design/dcc_speed_packet_serializer.sv
sim/dcc_speed_packet_serializer_tb.sv
